// ----- rtl/fbsc_pkg.sv -----
package fbsc_pkg;

    localparam int unsigned SECTOR_BYTES = 512;
    localparam int unsigned POS_W        = 10;
    localparam int unsigned RESULT_W     = 224;
    localparam int unsigned QUEUE_DEPTH  = 2;

    // Byte offsets of the captured boot sector fields.
    localparam logic [POS_W-1:0] POS_JUMP       = 10'd0;
    localparam logic [POS_W-1:0] POS_NAME_FIRST = 10'd3;
    localparam logic [POS_W-1:0] POS_NAME_LAST  = 10'd10;
    localparam logic [POS_W-1:0] POS_BPS_LO     = 10'h0B;
    localparam logic [POS_W-1:0] POS_BPS_HI     = 10'h0C;
    localparam logic [POS_W-1:0] POS_SPC        = 10'h0D;
    localparam logic [POS_W-1:0] POS_RSV_LO     = 10'h0E;
    localparam logic [POS_W-1:0] POS_RSV_HI     = 10'h0F;
    localparam logic [POS_W-1:0] POS_COPIES     = 10'h10;
    localparam logic [POS_W-1:0] POS_ROOT_LO    = 10'h11;
    localparam logic [POS_W-1:0] POS_ROOT_HI    = 10'h12;
    localparam logic [POS_W-1:0] POS_TOT16_LO   = 10'h13;
    localparam logic [POS_W-1:0] POS_TOT16_HI   = 10'h14;
    localparam logic [POS_W-1:0] POS_FAT16_LO   = 10'h16;
    localparam logic [POS_W-1:0] POS_FAT16_HI   = 10'h17;
    localparam logic [POS_W-1:0] POS_TOT32_B0   = 10'h20;
    localparam logic [POS_W-1:0] POS_TOT32_B3   = 10'h23;
    localparam logic [POS_W-1:0] POS_FAT32_B0   = 10'h24;
    localparam logic [POS_W-1:0] POS_FAT32_B3   = 10'h27;
    localparam logic [POS_W-1:0] POS_RCLUS_B0   = 10'h2C;
    localparam logic [POS_W-1:0] POS_RCLUS_B3   = 10'h2F;
    localparam logic [POS_W-1:0] POS_SIG_LO     = 10'd510;
    localparam logic [POS_W-1:0] POS_SIG_HI     = 10'd511;
    localparam logic [POS_W-1:0] POS_DONE       = 10'd512;

    localparam logic [63:0] NTFS_NAME  = "NTFS    ";
    localparam logic [63:0] EXFAT_NAME = "EXFAT   ";
    localparam logic [15:0] BOOT_SIG   = 16'hAA55;
    localparam logic [7:0]  JUMP_SHORT = 8'hEB;
    localparam logic [7:0]  JUMP_NEAR  = 8'hE9;
    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;

    localparam logic [2:0] FS_UNKNOWN = 3'd0;
    localparam logic [2:0] FS_FAT12   = 3'd1;
    localparam logic [2:0] FS_FAT16   = 3'd2;
    localparam logic [2:0] FS_FAT32   = 3'd3;
    localparam logic [2:0] FS_NTFS    = 3'd4;
    localparam logic [2:0] FS_EXFAT   = 3'd5;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_JUMP      = 4'd1;
    localparam logic [3:0] ERR_SIGNATURE = 4'd2;
    localparam logic [3:0] ERR_SECTOR    = 4'd3;
    localparam logic [3:0] ERR_CLUSTER   = 4'd4;
    localparam logic [3:0] ERR_RESERVED  = 4'd5;
    localparam logic [3:0] ERR_COPIES    = 4'd6;
    localparam logic [3:0] ERR_TOTAL     = 4'd7;
    localparam logic [3:0] ERR_FATSIZE   = 4'd8;

    // Everything the front captured for one sector.
    typedef struct packed {
        logic        jump_valid;
        logic        ntfs_match;
        logic        exfat_match;
        logic [15:0] sector_size;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved;
        logic [7:0]  copies;
        logic [15:0] root_entries;
        logic [31:0] total;
        logic [31:0] table_size;
        logic [31:0] root_dir_clus;
        logic [15:0] signature;
    } t_boot_snap;

    // Shift that divides by a one-hot cluster size.
    function automatic logic [2:0] spc_shift(input logic [7:0] spc);
        logic [2:0] sh;
        sh = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (spc[k]) begin
                sh = 3'(k);
            end
        end
        return sh;
    endfunction

endpackage

// ----- rtl/fbsc_front.sv -----
module fbsc_front
    import fbsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_boot_snap o_snap
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] pos;
    logic [2:0]       name_idx;
    logic [7:0]       ntfs_char, exfat_char;
    logic             accept;
    t_boot_snap       r_cap, n_cap;

    assign pos       = i_start ? '0 : r_pos;
    assign o_ready   = !(i_queue_full && pos == POS_SIG_HI);
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && pos == POS_SIG_HI;
    assign name_idx  = pos[2:0] - POS_NAME_FIRST[2:0];
    assign ntfs_char  = NTFS_NAME[63 - 8*name_idx -: 8];
    assign exfat_char = EXFAT_NAME[63 - 8*name_idx -: 8];

    always_comb begin
        n_cap = r_cap;
        n_pos = r_pos;
        if (accept && pos != POS_DONE) begin
            n_pos = pos + 1'b1;
            if (pos == POS_JUMP) begin
                n_cap.jump_valid = (i_byte == JUMP_SHORT) || (i_byte == JUMP_NEAR);
            end else if (pos >= POS_NAME_FIRST && pos <= POS_NAME_LAST) begin
                n_cap.ntfs_match  = (pos == POS_NAME_FIRST || r_cap.ntfs_match)
                                    && i_byte == ntfs_char;
                n_cap.exfat_match = (pos == POS_NAME_FIRST || r_cap.exfat_match)
                                    && i_byte == exfat_char;
            end else if (pos == POS_BPS_LO) begin
                n_cap.sector_size[7:0] = i_byte;
            end else if (pos == POS_BPS_HI) begin
                n_cap.sector_size[15:8] = i_byte;
            end else if (pos == POS_SPC) begin
                n_cap.cluster_sectors = i_byte;
            end else if (pos == POS_RSV_LO) begin
                n_cap.reserved[7:0] = i_byte;
            end else if (pos == POS_RSV_HI) begin
                n_cap.reserved[15:8] = i_byte;
            end else if (pos == POS_COPIES) begin
                n_cap.copies = i_byte;
            end else if (pos == POS_ROOT_LO) begin
                n_cap.root_entries[7:0] = i_byte;
            end else if (pos == POS_ROOT_HI) begin
                n_cap.root_entries[15:8] = i_byte;
            end else if (pos == POS_TOT16_LO) begin
                n_cap.total[7:0] = i_byte;
            end else if (pos == POS_TOT16_HI) begin
                n_cap.total[15:8] = i_byte;
            end else if (pos == POS_FAT16_LO) begin
                n_cap.table_size[7:0] = i_byte;
            end else if (pos == POS_FAT16_HI) begin
                n_cap.table_size[15:8] = i_byte;
            end else if (pos >= POS_TOT32_B0 && pos <= POS_TOT32_B3) begin
                n_cap.root_dir_clus = r_cap.root_dir_clus;
            end else if (pos >= POS_FAT32_B0 && pos <= POS_FAT32_B3) begin
                n_cap.root_dir_clus = r_cap.root_dir_clus;
            end else if (pos >= POS_RCLUS_B0 && pos <= POS_RCLUS_B3) begin
                n_cap.root_dir_clus[8*pos[1:0] +: 8] = i_byte;
            end else if (pos == POS_SIG_LO) begin
                n_cap.signature[7:0] = i_byte;
            end else if (pos == POS_SIG_HI) begin
                n_cap.signature[15:8] = i_byte;
            end
        end
    end

    // The 32-bit totals are kept apart from the 16-bit ones and merged on push.
    logic [31:0] r_tot_long, n_tot_long;
    logic [31:0] r_fat_long, n_fat_long;

    always_comb begin
        n_tot_long = r_tot_long;
        n_fat_long = r_fat_long;
        if (accept && pos >= POS_TOT32_B0 && pos <= POS_TOT32_B3) begin
            n_tot_long[8*pos[1:0] +: 8] = i_byte;
        end
        if (accept && pos >= POS_FAT32_B0 && pos <= POS_FAT32_B3) begin
            n_fat_long[8*pos[1:0] +: 8] = i_byte;
        end
    end

    always_comb begin
        o_snap            = n_cap;
        o_snap.total      = (n_cap.total[15:0] != '0) ? {16'd0, n_cap.total[15:0]}
                                                      : n_tot_long;
        o_snap.table_size = (n_cap.table_size[15:0] != '0)
                            ? {16'd0, n_cap.table_size[15:0]} : n_fat_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_cap      <= '0;
            r_tot_long <= '0;
            r_fat_long <= '0;
        end else begin
            r_pos      <= n_pos;
            r_cap      <= n_cap;
            r_tot_long <= n_tot_long;
            r_fat_long <= n_fat_long;
        end
    end

endmodule

// ----- rtl/fbsc_queue.sv -----
module fbsc_queue
    import fbsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_boot_snap i_data,
    output logic       o_full,
    input  logic       i_pop,
    output logic       o_valid,
    output t_boot_snap o_data
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_boot_snap       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = r_count == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if ((i_push && !o_full) && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!(i_push && !o_full) && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/fbsc_back.sv -----
module fbsc_back
    import fbsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_boot_snap          i_snap,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [RESULT_W-1:0] o_data
);

    // Stage one: checks, root directory sectors and first data sector.
    logic [2:0]  s0_kind;
    logic [3:0]  s0_err;
    logic        bps_ok, spc_ok;
    logic [21:0] root_num;
    logic [21:0] root_shifted;
    logic [12:0] root_sec;
    logic [33:0] first;

    always_comb begin
        bps_ok = i_snap.sector_size == 16'd512 || i_snap.sector_size == 16'd1024
              || i_snap.sector_size == 16'd2048 || i_snap.sector_size == 16'd4096;
        spc_ok = i_snap.cluster_sectors != '0
              && (i_snap.cluster_sectors & (i_snap.cluster_sectors - 8'd1)) == '0;
        s0_err = ERR_NONE;
        if (!i_snap.jump_valid) begin
            s0_err = ERR_JUMP;
        end else if (i_snap.signature != BOOT_SIG) begin
            s0_err = ERR_SIGNATURE;
        end else if (!bps_ok) begin
            s0_err = ERR_SECTOR;
        end else if (!spc_ok) begin
            s0_err = ERR_CLUSTER;
        end else if (i_snap.reserved == '0) begin
            s0_err = ERR_RESERVED;
        end else if (i_snap.copies == '0 || i_snap.copies > 8'd2) begin
            s0_err = ERR_COPIES;
        end else if (i_snap.total == '0) begin
            s0_err = ERR_TOTAL;
        end else if (i_snap.table_size == '0) begin
            s0_err = ERR_FATSIZE;
        end
        if (i_snap.ntfs_match) begin
            s0_kind = FS_NTFS;
        end else if (i_snap.exfat_match) begin
            s0_kind = FS_EXFAT;
        end else begin
            s0_kind = FS_UNKNOWN;
        end
    end

    always_comb begin
        root_num = {1'b0, i_snap.root_entries, 5'd0} + {6'd0, i_snap.sector_size} - 22'd1;
        unique case (i_snap.sector_size)
            16'd1024: root_shifted = root_num >> 10;
            16'd2048: root_shifted = root_num >> 11;
            16'd4096: root_shifted = root_num >> 12;
            default:  root_shifted = root_num >> 9;
        endcase
        root_sec = root_shifted[12:0];
        // Copies is one or two whenever the result is used.
        first = {18'd0, i_snap.reserved}
              + (i_snap.copies[1] ? {1'b0, i_snap.table_size, 1'b0}
                                  : {2'd0, i_snap.table_size})
              + {21'd0, root_sec};
    end

    logic        r_s1_valid;
    logic [2:0]  r_s1_kind;
    logic [3:0]  r_s1_err;
    t_boot_snap  r_s1_snap;
    logic [33:0] r_s1_first;
    logic [2:0]  r_s1_spc_sh;

    logic adv_out, take_s1, load_s1;

    assign adv_out = !o_valid || i_ready;
    assign take_s1 = r_s1_valid && adv_out;
    assign load_s1 = !r_s1_valid || take_s1;
    assign o_pop   = i_valid && load_s1;

    // Stage two: cluster count and FAT type.
    logic        under;
    logic [31:0] diff;
    logic [31:0] clus;
    logic [2:0]  fat_type;
    logic [RESULT_W-1:0] result;

    always_comb begin
        under = r_s1_first > {2'd0, r_s1_snap.total};
        diff  = r_s1_snap.total - r_s1_first[31:0];
        clus  = under ? '1 : (diff >> r_s1_spc_sh);
        if (under || clus >= FAT16_LIMIT) begin
            fat_type = FS_FAT32;
        end else if (clus < FAT12_LIMIT) begin
            fat_type = FS_FAT12;
        end else begin
            fat_type = FS_FAT16;
        end
        if (r_s1_kind != FS_UNKNOWN) begin
            result = {{(RESULT_W-3){1'b0}}, r_s1_kind};
        end else if (r_s1_err != ERR_NONE) begin
            result = {{(RESULT_W-7){1'b0}}, r_s1_err, FS_UNKNOWN};
        end else begin
            result = {clus,
                      r_s1_first,
                      (fat_type == FS_FAT32) ? r_s1_snap.root_dir_clus : 32'd0,
                      r_s1_snap.table_size,
                      r_s1_snap.total,
                      r_s1_snap.root_entries,
                      r_s1_snap.copies[1:0],
                      r_s1_snap.reserved,
                      r_s1_snap.cluster_sectors,
                      r_s1_snap.sector_size[12:0],
                      ERR_NONE,
                      fat_type};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_kind   <= s0_kind;
            r_s1_err    <= s0_err;
            r_s1_snap   <= i_snap;
            r_s1_first  <= first;
            r_s1_spc_sh <= spc_shift(i_snap.cluster_sectors);
        end
        if (take_s1) begin
            o_data <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_valid;
            end
            if (adv_out) begin
                o_valid <= r_s1_valid;
            end
        end
    end

endmodule

// ----- rtl/fat_boot_sector_classifier_unit.sv -----
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] = data_byte, tuser = sector_start
// m_axis    out  tdata[223:0] = one classification result per sector
//
// One byte is taken every cycle; the front never waits on the back unless two
// finished sectors are already queued and a third sector reaches byte 511.
// After the edge that takes byte 511, a sector's result passes through the queue and
// the check stage register, then the output register presents it.
// A stalled m_axis holds its beat while bytes keep flowing.
// Reset is synchronous and clears the byte position and all captured fields.
module fat_boot_sector_classifier_unit
    import fbsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
    input  logic                s_axis_tuser,  // [0] sector_start
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [2:0] fs_type, [6:3] error_code, [19:7] sector_size, [27:20] cluster_sectors,
    // [43:28] reserved_count, [45:44] table_copies, [61:46] root_entries,
    // [93:62] volume_sectors, [125:94] table_sectors, [157:126] root_start_cluster,
    // [191:158] data_start_sector, [223:192] clusters
    output logic [RESULT_W-1:0] m_axis_tdata
);

    logic       push, queue_full, pop, queue_valid;
    t_boot_snap push_snap, head_snap;

    fbsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_start      (s_axis_tuser),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_snap       (push_snap)
    );

    fbsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_data  (head_snap)
    );

    fbsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_snap  (head_snap),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
